// ===== rtl/core/htw_pkg.sv =====
// Package for the hashed timer wheel: sizes, codes, beat and storage types.
// Used by the channel interfaces and by the top level; depends on nothing.
package htw_pkg;
	localparam int SLOTS  = 16;
	localparam int TIMERS = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int LAPS_W = $clog2((65535 - 1) / SLOTS + 1);

	typedef enum logic [1:0] {
		KIND_ADDED = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_FIRED = 2'd2,
		KIND_IDLE  = 2'd3
	} kind_t;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADD_WR,
		ST_FULL,
		ST_WALK_RD,
		ST_WALK_EX,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        func;
		logic [15:0] delay;
		logic [15:0] timer_tag;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  handle;
		logic [15:0] fired_tag;
		logic [31:0] tick_count;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic              nv;
		logic [IDX_W-1:0]  ni;
		logic [LAPS_W-1:0] laps;
		logic [15:0]       tag;
	} entry_t;
endpackage

// ===== rtl/core/htw_in_if.sv =====
// Request channel of the hashed timer wheel: valid, ready and one request beat.
// Depends on htw_pkg for the beat type.
interface htw_in_if;
	logic              valid;
	logic              ready;
	htw_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/htw_out_if.sv =====
// Result channel of the hashed timer wheel: valid, ready and one result beat.
// Depends on htw_pkg for the beat type.
interface htw_out_if;
	logic               valid;
	logic               ready;
	htw_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/hashed_timer_wheel.sv =====
// Top level of the hashed timer wheel: sequencer, slot heads and entry memory.
// Depends on htw_pkg, htw_in_if and htw_out_if.
//
// One request beat is handled at a time. An add scans the pool one entry per
// cycle for the lowest free one and then links it in, or returns a full result
// if none is free. A tick walks the slot list through the single-port entry
// memory, reading each entry into a register and then updating it; the walk
// holds while an earlier fired result cannot enter the output register. Each
// result beat leaves through an output register; a stalled result holds the sequencer.
module hashed_timer_wheel (
	input logic      clk,
	input logic      arst_n,
	htw_in_if.sink   req,
	htw_out_if.source rsp
);
	htw_pkg::state_t state_q, state_d;

	logic [31:0]                tick_q;
	logic [htw_pkg::SLOTS-1:0]  head_v_q;
	logic [htw_pkg::IDX_W-1:0]  head_i_q [htw_pkg::SLOTS];
	logic [htw_pkg::TIMERS-1:0] active_q;
	htw_pkg::entry_t            mem_q [htw_pkg::TIMERS];
	htw_pkg::entry_t            rd_q;

	logic [htw_pkg::SLOT_W-1:0] slot_q;
	logic [htw_pkg::LAPS_W-1:0] laps_q;
	logic [15:0]                tag_q;
	logic [htw_pkg::IDX_W-1:0]  idx_q;
	logic                       cur_v_q;
	logic [htw_pkg::IDX_W-1:0]  cur_q;
	logic                       prev_v_q;
	logic [htw_pkg::IDX_W-1:0]  prev_q;
	htw_pkg::entry_t            prev_word_q;
	logic                       pend_v_q;
	logic [htw_pkg::IDX_W-1:0]  pend_i_q;
	logic [15:0]                pend_tag_q;
	logic                       out_v_q;
	htw_pkg::out_beat_t         out_q;

	logic                       out_free;
	logic                       accept;
	logic [15:0]                dly;
	logic [htw_pkg::SLOT_W-1:0] tick_slot;
	logic                       emit;
	htw_pkg::out_beat_t         emit_beat;
	logic                       mem_we;
	logic [htw_pkg::IDX_W-1:0]  mem_wa;
	htw_pkg::entry_t            mem_wd;
	logic                       mem_re;
	logic                       walk_go;
	logic                       laps_left;
	htw_pkg::entry_t            dec_word;
	htw_pkg::entry_t            link_word;

	assign out_free  = !out_v_q || rsp.ready;
	assign req.ready = (state_q == htw_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
	assign dly       = (req.data.delay == 16'd0) ? 16'd1 : req.data.delay;
	assign tick_slot = tick_q[htw_pkg::SLOT_W-1:0] + htw_pkg::SLOT_W'(1);
	assign laps_left = (rd_q.laps != '0);
	assign walk_go   = !(!laps_left && pend_v_q && !out_free);

	always_comb begin
		dec_word      = rd_q;
		dec_word.laps = rd_q.laps - htw_pkg::LAPS_W'(1);
		link_word     = prev_word_q;
		link_word.nv  = rd_q.nv;
		link_word.ni  = rd_q.ni;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htw_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.data.func == htw_pkg::FUNC_ADD) ? htw_pkg::ST_SCAN
						: htw_pkg::ST_WALK_RD;
				end
			end
			htw_pkg::ST_SCAN: begin
				if (!active_q[idx_q]) begin
					state_d = htw_pkg::ST_ADD_WR;
				end else if (idx_q == htw_pkg::IDX_W'(htw_pkg::TIMERS - 1)) begin
					state_d = htw_pkg::ST_FULL;
				end
			end
			htw_pkg::ST_ADD_WR, htw_pkg::ST_FULL, htw_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = htw_pkg::ST_IDLE;
				end
			end
			htw_pkg::ST_WALK_RD: begin
				state_d = cur_v_q ? htw_pkg::ST_WALK_EX : htw_pkg::ST_FINISH;
			end
			htw_pkg::ST_WALK_EX: begin
				if (walk_go) begin
					state_d = htw_pkg::ST_WALK_RD;
				end
			end
			default: state_d = htw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit                 = 1'b0;
		emit_beat            = '0;
		emit_beat.tick_count = tick_q;
		mem_we               = 1'b0;
		mem_wa               = cur_q;
		mem_wd               = dec_word;
		mem_re               = 1'b0;
		unique case (state_q)
			htw_pkg::ST_ADD_WR: begin
				emit             = out_free;
				emit_beat.kind   = htw_pkg::KIND_ADDED;
				emit_beat.handle = 6'(idx_q);
				emit_beat.last   = 1'b1;
				mem_we           = out_free;
				mem_wa           = idx_q;
				mem_wd.nv        = head_v_q[slot_q];
				mem_wd.ni        = head_i_q[slot_q];
				mem_wd.laps      = laps_q;
				mem_wd.tag       = tag_q;
			end
			htw_pkg::ST_FULL: begin
				emit           = out_free;
				emit_beat.kind = htw_pkg::KIND_FULL;
				emit_beat.last = 1'b1;
			end
			htw_pkg::ST_WALK_RD: begin
				mem_re = cur_v_q;
			end
			htw_pkg::ST_WALK_EX: begin
				if (walk_go) begin
					if (laps_left) begin
						mem_we = 1'b1;
					end else begin
						mem_we = prev_v_q;
						mem_wa = prev_q;
						mem_wd = link_word;
						emit   = pend_v_q;
					end
				end
				emit_beat.kind      = htw_pkg::KIND_FIRED;
				emit_beat.handle    = 6'(pend_i_q);
				emit_beat.fired_tag = pend_tag_q;
			end
			htw_pkg::ST_FINISH: begin
				emit           = out_free;
				emit_beat.last = 1'b1;
				if (pend_v_q) begin
					emit_beat.kind      = htw_pkg::KIND_FIRED;
					emit_beat.handle    = 6'(pend_i_q);
					emit_beat.fired_tag = pend_tag_q;
				end else begin
					emit_beat.kind = htw_pkg::KIND_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem_q[cur_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= htw_pkg::ST_IDLE;
			tick_q   <= '0;
			head_v_q <= '0;
			active_q <= '0;
			out_v_q  <= 1'b0;
			cur_v_q  <= 1'b0;
			prev_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (accept) begin
				prev_v_q <= 1'b0;
				pend_v_q <= 1'b0;
				if (req.data.func == htw_pkg::FUNC_TICK) begin
					tick_q  <= tick_q + 32'd1;
					cur_v_q <= head_v_q[tick_slot];
				end
			end
			if (state_q == htw_pkg::ST_ADD_WR && out_free) begin
				head_v_q[slot_q] <= 1'b1;
				active_q[idx_q]  <= 1'b1;
			end
			if (state_q == htw_pkg::ST_WALK_EX && walk_go) begin
				cur_v_q <= rd_q.nv;
				if (laps_left) begin
					prev_v_q <= 1'b1;
				end else begin
					pend_v_q        <= 1'b1;
					active_q[cur_q] <= 1'b0;
					if (!prev_v_q) begin
						head_v_q[slot_q] <= rd_q.nv;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_beat;
		end
		if (accept) begin
			idx_q  <= '0;
			tag_q  <= req.data.timer_tag;
			laps_q <= htw_pkg::LAPS_W'((dly - 16'd1) >> htw_pkg::SLOT_W);
			if (req.data.func == htw_pkg::FUNC_TICK) begin
				slot_q <= tick_slot;
				cur_q  <= head_i_q[tick_slot];
			end else begin
				slot_q <= tick_q[htw_pkg::SLOT_W-1:0] + dly[htw_pkg::SLOT_W-1:0];
			end
		end
		if (state_q == htw_pkg::ST_SCAN && active_q[idx_q]
				&& idx_q != htw_pkg::IDX_W'(htw_pkg::TIMERS - 1)) begin
			idx_q <= idx_q + htw_pkg::IDX_W'(1);
		end
		if (state_q == htw_pkg::ST_ADD_WR && out_free) begin
			head_i_q[slot_q] <= idx_q;
		end
		if (state_q == htw_pkg::ST_WALK_EX && walk_go) begin
			cur_q <= rd_q.ni;
			if (laps_left) begin
				prev_q      <= cur_q;
				prev_word_q <= dec_word;
			end else begin
				pend_i_q   <= cur_q;
				pend_tag_q <= rd_q.tag;
				if (prev_v_q) begin
					prev_word_q <= link_word;
				end else begin
					head_i_q[slot_q] <= rd_q.ni;
				end
			end
		end
	end
endmodule
